@@ design/pmst_pkg.sv @@
// Shared types and constants for the Prim-Jarnik spanning tree engine.
`timescale 1ns / 1ps
`default_nettype none

package pmst_pkg;

  localparam int unsigned VTX_W    = 7;   // vertex field width on the ports
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned DIST_W   = 17;  // distances, holds the initial value
  localparam int unsigned SUM_W    = 23;

  localparam logic [DIST_W-1:0] DIST_INIT = 17'd99999;

  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_RUN = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_RM_RD,
    ST_RM_RD2,
    ST_RM,
    ST_SD_L,
    ST_SD_R,
    ST_SD_CMP,
    ST_SC,
    ST_SC_E,
    ST_SC_P,
    ST_SC_H,
    ST_SU,
    ST_SU_C
  } st_e;

endpackage

`default_nettype wire

@@ design/prim_mst_binary_heap.sv @@
// An edge load is written straight to the edge store. A run sweeps the heap in init, then
// per removed vertex fetches it, sifts the last element down from the root and, but for the
// last vertex, scans every stored edge and sifts up each heap vertex that an edge makes
// lighter. Throughput: one item at a time; a run holds the input off until it ends,
// after its last result is made; a stalled output result holds the run. Reset: asynchronous,
// active low; clears the edge count, sets vertex_count to 1, empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module prim_mst_binary_heap #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned MAX_EDGES    = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: vertex_count
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [6:0]  cfg_data_i,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // end_a[6:0], end_b[13:7], weight[29:14], zero pad
  input  wire logic [0:0]  s_axis_tuser,   // func
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // vertex[6:0], total[29:7], zero pad
  output logic             m_axis_tlast    // last
);

  import pmst_pkg::*;

  localparam int unsigned VW  = $clog2(MAX_VERTICES);     // vertex minus one / heap slot
  localparam int unsigned CW  = $clog2(MAX_VERTICES + 1); // counts, 1-based positions
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ECW = $clog2(MAX_EDGES + 1);
  localparam int unsigned EDW = 2 * VW + WEIGHT_W;
  localparam int unsigned HDW = VW + DIST_W;

  // ---------------------------------------------------------------- state
  st_e                     state_q, state_d;
  logic [6:0]              vcount_q, vcount_d;
  logic [ECW-1:0]          edge_cnt_q, edge_cnt_d;
  logic [MAX_VERTICES-1:0] in_heap_q, in_heap_d;
  logic [CW-1:0]           i_q, i_d;         // current heap size before removal
  logic [VW-1:0]           k_q, k_d;         // init sweep slot
  logic [ECW-1:0]          e_q, e_d;         // edge scan, counts down
  logic [CW-1:0]           p_q, p_d;         // 1-based hole position
  logic [VW-1:0]           cur_v_q, cur_v_d; // element being sifted
  logic [DIST_W-1:0]       cur_d_q, cur_d_d;
  logic [VW-1:0]           lch_v_q, lch_v_d; // left child during sift-down
  logic [DIST_W-1:0]       lch_d_q, lch_d_d;
  logic [VW-1:0]           root_v_q, root_v_d;
  logic [DIST_W-1:0]       root_d_q, root_d_d;
  logic [SUM_W-1:0]        sum_q, sum_d;
  logic                    mvalid_q, mvalid_d;
  logic [VTX_W-1:0]        mvtx_q, mvtx_d;
  logic [SUM_W-1:0]        mtot_q, mtot_d;
  logic                    mlast_q, mlast_d;

  // ---------------------------------------------------------------- memories
  logic [EDW-1:0] edge_mem [MAX_EDGES];
  logic [HDW-1:0] heap_mem [MAX_VERTICES];
  logic [VW-1:0]  pos_mem  [MAX_VERTICES];

  logic           ed_we, ed_re;
  logic [EAW-1:0] ed_waddr, ed_raddr;
  logic [EDW-1:0] ed_wdata, ed_rdata_q;
  logic           hp_we, hp_re;
  logic [VW-1:0]  hp_waddr, hp_raddr;
  logic [HDW-1:0] hp_wdata, hp_rdata_q;
  logic           ps_we, ps_re;
  logic [VW-1:0]  ps_waddr, ps_raddr;
  logic [VW-1:0]  ps_wdata, ps_rdata_q;

  always_ff @(posedge clk_i) begin
    if (ed_we) begin
      edge_mem[ed_waddr] <= ed_wdata;
    end
    if (ed_re) begin
      ed_rdata_q <= edge_mem[ed_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hp_we) begin
      heap_mem[hp_waddr] <= hp_wdata;
    end
    if (hp_re) begin
      hp_rdata_q <= heap_mem[hp_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ps_we) begin
      pos_mem[ps_waddr] <= ps_wdata;
    end
    if (ps_re) begin
      ps_rdata_q <= pos_mem[ps_raddr];
    end
  end

  // ---------------------------------------------------------------- decode
  logic [CW-1:0]     n_eff;
  logic [6:0]        in_a, in_b;
  logic [WEIGHT_W-1:0] in_w;
  logic              edge_ok;
  logic [MAX_VERTICES-1:0] init_mask;
  logic              out_free;

  // clamp vertex_count to 1..MAX_VERTICES
  always_comb begin
    if (vcount_q == 7'd0) begin
      n_eff = CW'(1);
    end else if (vcount_q > 7'(MAX_VERTICES)) begin
      n_eff = CW'(MAX_VERTICES);
    end else begin
      n_eff = CW'(vcount_q);
    end
  end

  assign in_a = s_axis_tdata[6:0];
  assign in_b = s_axis_tdata[13:7];
  assign in_w = s_axis_tdata[29:14];
  assign edge_ok = (edge_cnt_q < ECW'(MAX_EDGES)) &&
                   (in_a != 7'd0) && (in_a <= 7'(n_eff)) &&
                   (in_b != 7'd0) && (in_b <= 7'(n_eff));

  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      init_mask[j] = (j < int'(n_eff));
    end
  end

  assign out_free = !mvalid_q || m_axis_tready;

  // heap word fields and sift-down index arithmetic
  logic [VW-1:0]     hr_v;
  logic [DIST_W-1:0] hr_d;
  logic [CW:0]       l_idx, r_idx, s_ext;
  logic              r_ok, use_r;
  logic [VW-1:0]     m_v;
  logic [DIST_W-1:0] m_d;
  logic [CW:0]       m_idx;
  logic [VW-1:0]     p_slot;
  logic [VW-1:0]     e_a, e_b, e_z;
  logic              e_hit;

  assign hr_v   = hp_rdata_q[HDW-1:DIST_W];
  assign hr_d   = hp_rdata_q[DIST_W-1:0];
  assign l_idx  = {p_q, 1'b0};
  assign r_idx  = l_idx + (CW+1)'(1);
  assign s_ext  = (CW+1)'(i_q - CW'(1));
  assign r_ok   = (r_idx <= s_ext);
  assign use_r  = r_ok && (hr_d < lch_d_q);          // left child wins ties
  assign m_v    = use_r ? hr_v : lch_v_q;
  assign m_d    = use_r ? hr_d : lch_d_q;
  assign m_idx  = use_r ? r_idx : l_idx;
  assign p_slot = VW'(p_q - CW'(1));

  assign e_a   = ed_rdata_q[EDW-1 -: VW];
  assign e_b   = ed_rdata_q[WEIGHT_W +: VW];
  assign e_hit = (e_a == root_v_q) || (e_b == root_v_q);
  assign e_z   = (e_a == root_v_q) ? e_b : e_a;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d    = state_q;
    vcount_d   = vcount_q;
    edge_cnt_d = edge_cnt_q;
    in_heap_d  = in_heap_q;
    i_d        = i_q;
    k_d        = k_q;
    e_d        = e_q;
    p_d        = p_q;
    cur_v_d    = cur_v_q;
    cur_d_d    = cur_d_q;
    lch_v_d    = lch_v_q;
    lch_d_d    = lch_d_q;
    root_v_d   = root_v_q;
    root_d_d   = root_d_q;
    sum_d      = sum_q;
    mvalid_d   = mvalid_q && !m_axis_tready;
    mvtx_d     = mvtx_q;
    mtot_d     = mtot_q;
    mlast_d    = mlast_q;

    ed_we    = 1'b0;
    ed_waddr = edge_cnt_q[EAW-1:0];
    ed_wdata = {VW'(in_a - 7'd1), VW'(in_b - 7'd1), in_w};
    ed_re    = 1'b0;
    ed_raddr = EAW'(e_q - ECW'(1));
    hp_we    = 1'b0;
    hp_waddr = p_slot;
    hp_wdata = {cur_v_q, cur_d_q};
    hp_re    = 1'b0;
    hp_raddr = '0;
    ps_we    = 1'b0;
    ps_waddr = cur_v_q;
    ps_wdata = p_slot;
    ps_re    = 1'b0;
    ps_raddr = cur_v_q;

    if (cfg_valid_i) begin
      vcount_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser[0] == FUNC_ADD) begin
            if (edge_ok) begin
              ed_we      = 1'b1;
              edge_cnt_d = edge_cnt_q + ECW'(1);
            end
          end else begin
            k_d       = '0;
            i_d       = n_eff;
            sum_d     = '0;
            in_heap_d = init_mask;
            state_d   = ST_INIT;
          end
        end
      end

      // vertex 1 at 0 in the root, all others at the initial distance:
      // already a valid heap, so bottom-up heapify moves nothing
      ST_INIT: begin
        hp_we    = 1'b1;
        hp_waddr = k_q;
        hp_wdata = {k_q, (k_q == '0) ? '0 : DIST_INIT};
        ps_we    = 1'b1;
        ps_waddr = k_q;
        ps_wdata = k_q;
        k_d      = k_q + VW'(1);
        if (CW'(k_q) == n_eff - CW'(1)) begin
          state_d = ST_RM_RD;
        end
      end

      ST_RM_RD: begin
        hp_re    = 1'b1;
        hp_raddr = '0;
        state_d  = ST_RM_RD2;
      end

      ST_RM_RD2: begin
        root_v_d = hr_v;
        root_d_d = hr_d;
        hp_re    = 1'b1;
        hp_raddr = VW'(i_q - CW'(1));
        state_d  = ST_RM;
      end

      // last element moves to the root hole; result goes out here
      ST_RM: begin
        if (out_free) begin
          sum_d     = sum_q + SUM_W'(root_d_q);
          mvalid_d  = 1'b1;
          mvtx_d    = VTX_W'(root_v_q) + VTX_W'(1);
          mtot_d    = sum_q + SUM_W'(root_d_q);
          mlast_d   = (i_q == CW'(1));
          in_heap_d[root_v_q] = 1'b0;
          cur_v_d   = hr_v;
          cur_d_d   = hr_d;
          p_d       = CW'(1);
          e_d       = edge_cnt_q;
          state_d   = ST_SD_L;
        end
      end

      ST_SD_L: begin
        if (l_idx > s_ext) begin
          hp_we = 1'b1;
          ps_we = 1'b1;
          if (i_q == CW'(1)) begin
            edge_cnt_d = '0;
            state_d    = ST_IDLE;
          end else begin
            state_d = ST_SC;
          end
        end else begin
          hp_re    = 1'b1;
          hp_raddr = VW'(l_idx - (CW+1)'(1));
          state_d  = ST_SD_R;
        end
      end

      ST_SD_R: begin
        lch_v_d  = hr_v;
        lch_d_d  = hr_d;
        hp_re    = r_ok;
        hp_raddr = VW'(r_idx - (CW+1)'(1));
        state_d  = ST_SD_CMP;
      end

      ST_SD_CMP: begin
        if (!use_r) begin
          // hr_* still hold the left child when the right one is absent
        end
        if (cur_d_q <= m_d) begin
          hp_we   = 1'b1;
          ps_we   = 1'b1;
          state_d = ST_SC;
        end else begin
          hp_we    = 1'b1;
          hp_wdata = {m_v, m_d};
          ps_we    = 1'b1;
          ps_waddr = m_v;
          p_d      = CW'(m_idx);
          state_d  = ST_SD_L;
        end
      end

      // edges scanned from the newest down
      ST_SC: begin
        if (e_q == '0) begin
          i_d     = i_q - CW'(1);
          state_d = ST_RM_RD;
        end else begin
          ed_re   = 1'b1;
          e_d     = e_q - ECW'(1);
          state_d = ST_SC_E;
        end
      end

      ST_SC_E: begin
        if (e_hit && in_heap_q[e_z]) begin
          cur_v_d  = e_z;
          cur_d_d  = DIST_W'(ed_rdata_q[WEIGHT_W-1:0]);
          ps_re    = 1'b1;
          ps_raddr = e_z;
          state_d  = ST_SC_P;
        end else begin
          state_d = ST_SC;
        end
      end

      ST_SC_P: begin
        p_d      = CW'(ps_rdata_q) + CW'(1);
        hp_re    = 1'b1;
        hp_raddr = ps_rdata_q;
        state_d  = ST_SC_H;
      end

      ST_SC_H: begin
        state_d = (cur_d_q < hr_d) ? ST_SU : ST_SC;
      end

      ST_SU: begin
        if (p_q == CW'(1)) begin
          hp_we   = 1'b1;
          ps_we   = 1'b1;
          state_d = ST_SC;
        end else begin
          hp_re    = 1'b1;
          hp_raddr = VW'((p_q >> 1) - CW'(1));
          state_d  = ST_SU_C;
        end
      end

      ST_SU_C: begin
        hp_we = 1'b1;
        ps_we = 1'b1;
        if (cur_d_q < hr_d) begin
          hp_wdata = hp_rdata_q;
          ps_waddr = hr_v;
          p_d      = p_q >> 1;
          state_d  = ST_SU;
        end else begin
          state_d = ST_SC;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      vcount_q   <= 7'd1;
      edge_cnt_q <= '0;
      in_heap_q  <= '0;
      i_q        <= '0;
      k_q        <= '0;
      e_q        <= '0;
      p_q        <= '0;
      mvalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      vcount_q   <= vcount_d;
      edge_cnt_q <= edge_cnt_d;
      in_heap_q  <= in_heap_d;
      i_q        <= i_d;
      k_q        <= k_d;
      e_q        <= e_d;
      p_q        <= p_d;
      mvalid_q   <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_v_q  <= cur_v_d;
    cur_d_q  <= cur_d_d;
    lch_v_q  <= lch_v_d;
    lch_d_q  <= lch_d_d;
    root_v_q <= root_v_d;
    root_d_q <= root_d_d;
    sum_q    <= sum_d;
    mvtx_q   <= mvtx_d;
    mtot_q   <= mtot_d;
    mlast_q  <= mlast_d;
  end

  // ---------------------------------------------------------------- ports
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {2'b00, mtot_q, mvtx_q};
  assign m_axis_tlast  = mlast_q;

`ifndef SYNTH
  // heap occupancy matches the size count at each removal
  a_heap_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RM_RD) |-> ($countones(in_heap_q) == int'(i_q)))
    else $error("heap membership out of step with heap size");

  // a relax only looks up vertices still in the heap
  a_relax_member: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SC_P) |-> in_heap_q[cur_v_q])
    else $error("relax on a removed vertex");

  // a finished run leaves the edge store empty
  a_run_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != ST_IDLE) ##1 (state_q == ST_IDLE)) |-> (edge_cnt_q == '0))
    else $error("edge store not cleared after run");
`endif

endmodule

`default_nettype wire
